@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition at one edge that forces another at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fsk_pkg.sv @@
// Package for the FSK UART modulator: sizes, frame positions, register
// indexes, control structs and the sine code table. No dependencies.
package fsk_pkg;

	// Table and phase accumulator geometry (table length is a power of two).
	localparam int TABLE_LEN  = 256;
	localparam int PHASE_FRAC = 16;
	localparam int IDX_W      = $clog2(TABLE_LEN);
	localparam int PHASE_W    = IDX_W + PHASE_FRAC;
	localparam int STEP_W     = 24;
	localparam int TPB_W      = 10;
	localparam int SAMPLE_W   = 12;
	localparam int POS_W      = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_STEP     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_STEP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BIT = 2'd2;

	// Register reset values.
	localparam logic [STEP_W-1:0] MARK_STEP_RST     = 24'd364619;
	localparam logic [STEP_W-1:0] SPACE_STEP_RST    = 24'd668467;
	localparam logic [TPB_W-1:0]  TICKS_PER_BIT_RST = 10'd46;

	// Frame positions.
	localparam logic [POS_W-1:0] POS_LEAD   = 4'd0;
	localparam logic [POS_W-1:0] POS_START  = 4'd1;
	localparam logic [POS_W-1:0] POS_DATA0  = 4'd2;
	localparam logic [POS_W-1:0] POS_PARITY = 4'd10;
	localparam logic [POS_W-1:0] POS_STOP   = 4'd11;
	localparam logic [POS_W-1:0] POS_IDLE   = 4'd12;

	// Commands from the top level to the frame sequencer.
	typedef struct packed {
		logic load;
		logic tick;
	} frame_cmd_t;

	// Status from the frame sequencer.
	typedef struct packed {
		logic line_bit;
		logic idle_next;
	} frame_stat_t;

	typedef logic [SAMPLE_W-1:0] sine_tab_t [TABLE_LEN];

	// Taylor series divisors (2k)(2k+1) for k = 1..6.
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAB_N       = 64'(TABLE_LEN);

	// Builds the sine code table at elaboration: quarter-wave fold, Q30 angle,
	// Taylor series to the x^13 term, clamp, offset and saturate to 12 bits.
	function automatic sine_tab_t build_sine();
		sine_tab_t tab;
		logic [63:0] a, r, t, x, x2, term, code;
		longint s, v;
		logic neg;
		for (int i = 0; i < TABLE_LEN; i++) begin
			a = 64'(4 * i);
			neg = 1'b0;
			if (a <= TAB_N) begin
				r = a;
			end else if (a <= 2 * TAB_N) begin
				r = 2 * TAB_N - a;
			end else if (a <= 3 * TAB_N) begin
				r = a - 2 * TAB_N;
				neg = 1'b1;
			end else begin
				r = 4 * TAB_N - a;
				neg = 1'b1;
			end
			t = (r << 30) / TAB_N;
			x = (t * HALF_PI_Q30) >> 30;
			x2 = (x * x) >> 30;
			term = x;
			s = longint'(x);
			for (int k = 0; k < 6; k++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[k];
				if (k % 2 == 0) begin
					s = s - longint'(term);
				end else begin
					s = s + longint'(term);
				end
			end
			if (s < 0) begin
				s = 0;
			end
			if (s > longint'(Q30_ONE)) begin
				s = longint'(Q30_ONE);
			end
			v = neg ? (longint'(Q30_ONE) - s) : (longint'(Q30_ONE) + s);
			code = 64'(v) >> 19;
			tab[i] = (code > 64'd4095) ? 12'd4095 : code[SAMPLE_W-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

endpackage

@@ rtl/fsk_if.sv @@
// Valid/ready channel interfaces for the modulator's input items and results.
// Depends on fsk_pkg.
interface fsk_in_if;
	import fsk_pkg::*;

	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] char_in;

	modport source (output valid, output mode, output char_in, input ready);
	modport sink (input valid, input mode, input char_in, output ready);
endinterface

interface fsk_out_if;
	import fsk_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                ready_res;
	logic                line_bit;

	modport source (output valid, output sample, output ready_res, output line_bit,
		input ready);
	modport sink (input valid, input sample, input ready_res, input line_bit,
		output ready);
endinterface

@@ rtl/fsk_frame.sv @@
// Serial frame sequencer: lead-in, start, eight data bits, parity, stop, idle.
// Depends on fsk_pkg.
module fsk_frame (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fsk_pkg::frame_cmd_t       cmd,
	input  logic [7:0]                char_in,
	input  logic [fsk_pkg::TPB_W-1:0] ticks_per_bit,
	output fsk_pkg::frame_stat_t      stat
);
	import fsk_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [TPB_W-1:0] tick_cnt_q;
	logic             idle_q;
	logic [7:0]       shift_q;
	logic             parity_q;

	logic [TPB_W-1:0] tpb_eff;
	logic [TPB_W-1:0] tick_inc;
	logic             bit_end;
	logic             cur_bit;
	logic [2:0]       data_sel;

	// Bit on the line for the current frame position.
	always_comb begin
		data_sel = 3'(pos_q - POS_DATA0);
		if (idle_q || pos_q == POS_LEAD || pos_q >= POS_STOP) begin
			cur_bit = 1'b1;
		end else if (pos_q == POS_START) begin
			cur_bit = 1'b0;
		end else if (pos_q == POS_PARITY) begin
			cur_bit = parity_q;
		end else begin
			cur_bit = shift_q[data_sel];
		end
	end

	// Bit period counting; a zero period counts as one tick.
	assign tpb_eff  = (ticks_per_bit == '0) ? TPB_W'(1) : ticks_per_bit;
	assign tick_inc = tick_cnt_q + TPB_W'(1);
	assign bit_end  = (tick_inc >= tpb_eff);

	assign stat.line_bit  = cur_bit;
	assign stat.idle_next = idle_q || (bit_end && pos_q >= POS_STOP);

	// Frame position, tick count and idle flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_IDLE;
			tick_cnt_q <= '0;
			idle_q     <= 1'b1;
		end else if (cmd.load && idle_q) begin
			pos_q      <= POS_LEAD;
			tick_cnt_q <= '0;
			idle_q     <= 1'b0;
		end else if (cmd.tick && !idle_q) begin
			if (bit_end) begin
				tick_cnt_q <= '0;
				if (pos_q >= POS_STOP) begin
					pos_q  <= POS_IDLE;
					idle_q <= 1'b1;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end else begin
				tick_cnt_q <= tick_inc;
			end
		end
	end

	// Byte and parity latched by a load taken while idle.
	always_ff @(posedge clk) begin
		if (cmd.load && idle_q) begin
			shift_q  <= char_in;
			parity_q <= ^char_in;
		end
	end

endmodule

@@ rtl/fsk_dds.sv @@
// Phase accumulator and sine table lookup for the tone synthesis.
// Depends on fsk_pkg.
module fsk_dds (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tick,
	input  logic                         line_bit,
	input  logic [fsk_pkg::STEP_W-1:0]   mark_step,
	input  logic [fsk_pkg::STEP_W-1:0]   space_step,
	output logic [fsk_pkg::SAMPLE_W-1:0] sample
);
	import fsk_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [STEP_W-1:0]  step;
	logic [IDX_W-1:0]   tab_idx;

	// The sample comes from the phase before this tick's add.
	assign tab_idx = phase_q[PHASE_W-1 -: IDX_W];
	assign sample  = SINE_TAB[tab_idx];
	assign step    = line_bit ? mark_step : space_step;

	// Phase wraps at the table length through truncation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (tick) begin
			phase_q <= PHASE_W'(phase_q + PHASE_W'(step));
		end
	end

endmodule

@@ rtl/fsk_uart_modulator.sv @@
// Latency: a tick item's result is valid the cycle after its transfer; loads give none.
// Throughput: one item per cycle if results are taken; that frees the output register.
// The sample path is one phase register feeding the constant sine table, then sample_q.
// Reset (arst_n low, asynchronous): idle frame, phase zero, registers at defaults.
// Depends on fsk_pkg, fsk_if, fsk_frame and fsk_dds.
module fsk_uart_modulator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fsk_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [fsk_pkg::STEP_W-1:0]    cfg_wdata,
	fsk_in_if.sink                        items,
	fsk_out_if.source                     results
);
	import fsk_pkg::*;

	logic [STEP_W-1:0]   mark_step_q;
	logic [STEP_W-1:0]   space_step_q;
	logic [TPB_W-1:0]    tpb_q;

	logic                res_valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                ready_res_q;
	logic                line_bit_q;

	logic                accept;
	frame_cmd_t          cmd;
	frame_stat_t         stat;
	logic [SAMPLE_W-1:0] sample_now;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_step_q  <= MARK_STEP_RST;
			space_step_q <= SPACE_STEP_RST;
			tpb_q        <= TICKS_PER_BIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MARK_STEP:     mark_step_q  <= cfg_wdata;
				CFG_SPACE_STEP:    space_step_q <= cfg_wdata;
				CFG_TICKS_PER_BIT: tpb_q        <= cfg_wdata[TPB_W-1:0];
				default: ;
			endcase
		end
	end

	// An item transfers whenever the output register is empty or being emptied.
	assign items.ready = !res_valid_q || results.ready;
	assign accept      = items.valid && items.ready;
	assign cmd.tick    = accept && !items.mode;
	assign cmd.load    = accept && items.mode;

	fsk_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.char_in       (items.char_in),
		.ticks_per_bit (tpb_q),
		.stat          (stat)
	);

	fsk_dds u_dds (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (cmd.tick),
		.line_bit   (stat.line_bit),
		.mark_step  (mark_step_q),
		.space_step (space_step_q),
		.sample     (sample_now)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.tick) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload captured on each tick transfer.
	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			sample_q    <= sample_now;
			ready_res_q <= stat.idle_next;
			line_bit_q  <= stat.line_bit;
		end
	end

	assign results.valid     = res_valid_q;
	assign results.sample    = sample_q;
	assign results.ready_res = ready_res_q;
	assign results.line_bit  = line_bit_q;

endmodule

@@ rtl/fsk_checker.sv @@
// Port-level checker for the FSK UART modulator, bound to the top level.
// Depends on assert_macros.svh and fsk_pkg.
`include "assert_macros.svh"

module fsk_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         in_mode,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [fsk_pkg::SAMPLE_W-1:0] out_sample,
	input logic                         out_ready_res,
	input logic                         out_line_bit
);
	import fsk_pkg::*;

	logic in_xfer;
	logic out_free;

	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// A stalled result holds its payload.
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(out_line_bit) && $stable(out_ready_res), "stalled result changed")

	// Every tick transfer yields a result in the next cycle.
	`ASSERT_NEXT(a_tick_result, clk, arst_n, in_xfer && !in_mode, out_valid, "tick gave no result")

	// A load transfer yields no result.
	`ASSERT_NEXT(a_load_silent, clk, arst_n, in_xfer && in_mode && out_free, !out_valid, "load gave a result")

	// A space bit is never the last bit of a frame, so the block is still busy.
	`ASSERT_ALWAYS(a_space_busy, clk, arst_n, !(out_valid && !out_line_bit && out_ready_res), "idle after a space bit")

endmodule

bind fsk_uart_modulator fsk_checker u_fsk_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (items.valid),
	.in_ready      (items.ready),
	.in_mode       (items.mode),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.out_sample    (results.sample),
	.out_ready_res (results.ready_res),
	.out_line_bit  (results.line_bit)
);
